// ----- hdl/rwoa_pkg.sv -----
// Package for the random walk obstacle avoider.
// Holds scan geometry constants, register indexes and the item opcodes.
// No dependencies.
package rwoa_pkg;

  localparam int MAX_SCAN   = 1024;
  localparam int RANGE_BITS = 16;
  localparam int POS_W      = $clog2(MAX_SCAN);
  localparam int SCAN_W     = POS_W + 1;

  localparam int TIMER_W    = 16;
  localparam int SPEED_W    = 11;
  localparam int TURN_W     = 8;
  localparam int ATURN_W    = 7;
  localparam int SPC_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int RND_W      = 16;
  localparam int RND_MOD    = 41;
  localparam int RND_BIAS   = 20;
  localparam int RND_SHIFT  = 22;
  localparam int RND_RECIP  = (1 << RND_SHIFT) / RND_MOD + 1;
  localparam int RND_MUL_W  = 17;
  localparam int RMOD_W     = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OBSTACLE_DIST = 3'd0,
    REG_AVOID_TIME    = 3'd1,
    REG_COURSE_CHANGE = 3'd2,
    REG_CRUISE_SPEED  = 3'd3,
    REG_AVOID_SPEED   = 3'd4,
    REG_AVOID_TURN    = 3'd5,
    REG_SAMPLES_SCAN  = 3'd6
  } reg_idx_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_t;

endpackage

// ----- hdl/random_walk_obstacle_avoider.sv -----
// Random walk obstacle avoider: one speed and turn command per range scan.
// Depends on rwoa_pkg.
//
// Usage:
//   in_*  : one item per handshake. in_tuser is the opcode (sample or
//           one millisecond tick); in_tdata carries range and random draw.
//   out_* : one command item at the end of each scan (speed and turn).
//   cfg_* : register writes, by the user only while the block is idle; unenforced.
// Path: an item is captured in the input register and processed from there
//   once the processing stage moves; the command of the last sample of a scan
//   is then loaded into the output register.
// Throughput: one item per cycle. Only a scan end that meets a full output
//   register whose item is not taken holds the processing stage, and with
//   it in_tready; samples and ticks that give no command always move on.
// Reset: rst_n clears the scan, the timers, the modes and both stages, and
//   loads the registers with their default values.
// Stall: while out_tready is low the command holds in the output register;
//   samples and ticks keep moving, the next scan end waits in the input
//   register and in_tready drops until the command is taken.
// The random draw is reduced modulo 41 before the input register by a
//   reciprocal multiplication.
module random_walk_obstacle_avoider
  import rwoa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,  // range_mm [15:0], random_value [31:16]
  input  logic                  in_tuser,  // opcode [0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata, // speed_mms [10:0], turn_deg [18:11]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [15:0]         obst_dist_r;
  logic [TIMER_W-1:0]  avoid_time_r;
  logic [TIMER_W-1:0]  course_chg_r;
  logic [SPEED_W-1:0]  cruise_spd_r;
  logic [SPEED_W-1:0]  avoid_spd_r;
  logic [ATURN_W-1:0]  avoid_turn_r;
  logic [SPC_W-1:0]    spc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obst_dist_r  <= 16'd750;
      avoid_time_r <= TIMER_W'(1500);
      course_chg_r <= TIMER_W'(2000);
      cruise_spd_r <= SPEED_W'(200);
      avoid_spd_r  <= SPEED_W'(-50);
      avoid_turn_r <= ATURN_W'(40);
      spc_r        <= SPC_W'(361);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OBSTACLE_DIST: obst_dist_r  <= cfg_data;
        REG_AVOID_TIME:    avoid_time_r <= cfg_data;
        REG_COURSE_CHANGE: course_chg_r <= cfg_data;
        REG_CRUISE_SPEED:  cruise_spd_r <= cfg_data[SPEED_W-1:0];
        REG_AVOID_SPEED:   avoid_spd_r  <= cfg_data[SPEED_W-1:0];
        REG_AVOID_TURN:    avoid_turn_r <= cfg_data[ATURN_W-1:0];
        REG_SAMPLES_SCAN:  spc_r        <= cfg_data[SPC_W-1:0];
        default: ;
      endcase
    end
  end

  // random draw modulo 41
  logic [RND_W-1:0]             rnd_in;
  logic [RND_W+RND_MUL_W-1:0]   rnd_prod;
  logic [RND_W-1:0]             rnd_quot;
  logic [RND_W-1:0]             rnd_rem;
  logic [RMOD_W-1:0]            rnd_mod;

  assign rnd_in   = in_tdata[31:16];
  assign rnd_prod = (RND_W+RND_MUL_W)'(rnd_in) * (RND_W+RND_MUL_W)'(RND_RECIP);
  assign rnd_quot = RND_W'(rnd_prod >> RND_SHIFT);
  assign rnd_rem  = rnd_in - RND_W'(rnd_quot * RND_W'(RND_MOD));
  assign rnd_mod  = rnd_rem[RMOD_W-1:0];

  // input register
  logic                  stg_valid_r;
  logic                  stg_op_r;
  logic [RANGE_BITS-1:0] stg_range_r;
  logic [RMOD_W-1:0]     stg_rmod_r;
  logic                  stg_go;
  logic                  stg_end;

  assign stg_go    = stg_valid_r && (!stg_end || !out_tvalid || out_tready);
  assign in_tready = !stg_valid_r || stg_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_op_r    <= in_tuser;
      stg_range_r <= in_tdata[RANGE_BITS-1:0];
      stg_rmod_r  <= rnd_mod;
    end
  end

  // scan and mode state
  logic [POS_W-1:0]      pos_r,   pos_nxt;
  logic                  obst_r,  obst_nxt;
  logic [RANGE_BITS-1:0] lmin_r,  lmin_nxt;
  logic [RANGE_BITS-1:0] rmin_r,  rmin_nxt;
  logic                  avoid_r, avoid_nxt;
  logic                  tleft_r, tleft_nxt;
  logic                  force_r, force_nxt;
  logic [TIMER_W-1:0]    av_el_r, av_el_nxt;
  logic [TIMER_W-1:0]    co_el_r, co_el_nxt;

  logic [SCAN_W-1:0]         n_eff;
  logic [SCAN_W-1:0]         pos_ext;
  logic                      av_cond;
  logic                      scan_obst;
  logic [RANGE_BITS-1:0]     scan_lmin;
  logic [RANGE_BITS-1:0]     scan_rmin;
  logic                      cur_tleft;
  logic [TIMER_W-1:0]        cur_av_el;
  logic signed [SPEED_W-1:0] res_speed;
  logic signed [TURN_W-1:0]  res_turn;
  logic [TURN_W-1:0]         aturn_ext;

  always_comb begin
    if (int'(spc_r) < 2) begin
      n_eff = SCAN_W'(2);
    end else if (int'(spc_r) > MAX_SCAN) begin
      n_eff = SCAN_W'(MAX_SCAN);
    end else begin
      n_eff = SCAN_W'(spc_r);
    end
    pos_ext   = {1'b0, pos_r};
    stg_end   = (stg_op_r == OP_SAMPLE) && ((pos_ext + SCAN_W'(1)) >= n_eff);
    aturn_ext = {1'b0, avoid_turn_r};

    scan_obst = obst_r || (stg_range_r < obst_dist_r[RANGE_BITS-1:0]);
    scan_lmin = lmin_r;
    scan_rmin = rmin_r;
    if (pos_ext < (n_eff >> 1)) begin
      if (stg_range_r < rmin_r) begin
        scan_rmin = stg_range_r;
      end
    end else if (stg_range_r < lmin_r) begin
      scan_lmin = stg_range_r;
    end

    av_cond   = scan_obst || (av_el_r < avoid_time_r);
    cur_tleft = avoid_r ? tleft_r : (scan_rmin < scan_lmin);
    cur_av_el = avoid_r ? av_el_r : '0;

    pos_nxt   = pos_r;
    obst_nxt  = obst_r;
    lmin_nxt  = lmin_r;
    rmin_nxt  = rmin_r;
    avoid_nxt = avoid_r;
    tleft_nxt = tleft_r;
    force_nxt = force_r;
    av_el_nxt = av_el_r;
    co_el_nxt = co_el_r;
    res_speed = $signed(cruise_spd_r);
    res_turn  = '0;

    if (stg_op_r == OP_TICK) begin
      if (av_el_r != '1) av_el_nxt = av_el_r + TIMER_W'(1);
      if (co_el_r != '1) co_el_nxt = co_el_r + TIMER_W'(1);
    end else if (!stg_end) begin
      pos_nxt  = pos_r + POS_W'(1);
      obst_nxt = scan_obst;
      lmin_nxt = scan_lmin;
      rmin_nxt = scan_rmin;
    end else begin
      pos_nxt  = '0;
      obst_nxt = 1'b0;
      lmin_nxt = '1;
      rmin_nxt = '1;
      if (av_cond) begin
        tleft_nxt = cur_tleft;
        av_el_nxt = cur_av_el;
        avoid_nxt = 1'b1;
        res_speed = $signed(avoid_spd_r);
        res_turn  = cur_tleft ? $signed(aturn_ext) : $signed(TURN_W'(-aturn_ext));
        if (cur_av_el >= avoid_time_r) begin
          avoid_nxt = 1'b0;
          force_nxt = 1'b1;
        end
      end else if (force_r || (co_el_r >= course_chg_r)) begin
        res_turn  = $signed(TURN_W'(stg_rmod_r) - TURN_W'(RND_BIAS));
        force_nxt = 1'b0;
        co_el_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      obst_r  <= 1'b0;
      lmin_r  <= '1;
      rmin_r  <= '1;
      avoid_r <= 1'b0;
      tleft_r <= 1'b0;
      force_r <= 1'b0;
      av_el_r <= '0;
      co_el_r <= '0;
    end else if (stg_go) begin
      pos_r   <= pos_nxt;
      obst_r  <= obst_nxt;
      lmin_r  <= lmin_nxt;
      rmin_r  <= rmin_nxt;
      avoid_r <= avoid_nxt;
      tleft_r <= tleft_nxt;
      force_r <= force_nxt;
      av_el_r <= av_el_nxt;
      co_el_r <= co_el_nxt;
    end
  end

  // output register
  logic                      out_valid_r;
  logic signed [SPEED_W-1:0] out_speed_r;
  logic signed [TURN_W-1:0]  out_turn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_go && stg_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_go && stg_end) begin
      out_speed_r <= res_speed;
      out_turn_r  <= res_turn;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_turn_r, out_speed_r};

  a_cmd_from_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(stg_valid_r && stg_op_r == OP_SAMPLE))
    else $error("command without a scan end");

  a_cruise_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_go && stg_end && !av_cond) |=>
      (out_turn_r >= -TURN_W'(RND_BIAS) && out_turn_r <= TURN_W'(RND_BIAS)))
    else $error("cruise turn out of range");

  a_avoid_timer: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (av_el_r >= $past(av_el_r) || av_el_r == '0))
    else $error("avoid timer moved backward");

  a_tick_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_go && stg_op_r == OP_TICK) |=> $stable(pos_r) && $stable(lmin_r))
    else $error("tick changed scan state");

endmodule
